[hdl/pas_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pas_pkg;

	// table size
	localparam int NUM_ALARMS = 8;
	localparam int IDX_W      = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
	localparam int CNT_W      = $clog2(NUM_ALARMS + 1);

	// field widths
	localparam int OP_W      = 2;
	localparam int IN_TIME_W = 63;
	localparam int SLOT_W    = 3;
	localparam int TIME_W    = 64;
	localparam int STAMP_W   = 32;
	localparam int DIV_CNT_W = $clog2(TIME_W);

	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	// op codes
	localparam logic [OP_W-1:0] OP_PUMP     = 2'd0;
	localparam logic [OP_W-1:0] OP_ONE_SHOT = 2'd1;
	localparam logic [OP_W-1:0] OP_PERIODIC = 2'd2;
	localparam logic [OP_W-1:0] OP_CANCEL   = 2'd3;

	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] dividend;
		logic [TIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] rem;
	} div_rsp_t;

endpackage

`default_nettype wire

[hdl/pas_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pas_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [pas_pkg::OP_W-1:0]       op;
	logic [pas_pkg::IN_TIME_W-1:0]  now;
	logic [pas_pkg::SLOT_W-1:0]     slot;
	logic [pas_pkg::IN_TIME_W-1:0]  delay;
	logic [pas_pkg::IN_TIME_W-1:0]  start_time;
	logic [pas_pkg::IN_TIME_W-1:0]  repeat_period;
	logic                           has_handler;

	modport source (output valid, op, now, slot, delay, start_time, repeat_period,
		has_handler, input ready);
	modport sink (input valid, op, now, slot, delay, start_time, repeat_period,
		has_handler, output ready);
endinterface

`default_nettype wire

[hdl/pas_evt_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pas_evt_if;
	logic                       valid;
	logic                       ready;
	logic [pas_pkg::SLOT_W-1:0] fired_slot;
	logic                       last;

	modport source (output valid, fired_slot, last, input ready);
	modport sink (input valid, fired_slot, last, output ready);
endinterface

`default_nettype wire

[hdl/pas_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module pas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/pas_rem_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle.
module pas_rem_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pas_pkg::div_req_t req,
	output pas_pkg::div_rsp_t      rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [pas_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [pas_pkg::TIME_W-1:0]      dvd_q;
	logic [pas_pkg::TIME_W-1:0]      dsr_q;
	logic [pas_pkg::TIME_W-1:0]      rem_q;
	logic [pas_pkg::TIME_W:0]        trial;
	logic                            fits;

	assign trial = {rem_q, dvd_q[pas_pkg::TIME_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= pas_pkg::DIV_CNT_W'(pas_pkg::TIME_W - 1);
				dvd_q  <= req.dividend;
				dsr_q  <= req.divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				// shift in one bit, subtract where it fits
				if (fits) begin
					rem_q <= pas_pkg::TIME_W'(trial - {1'b0, dsr_q});
				end else begin
					rem_q <= trial[pas_pkg::TIME_W-1:0];
				end
				dvd_q <= {dvd_q[pas_pkg::TIME_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

[hdl/periodic_alarm_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Role  | Payload                                             | Moves
// cmd     | sink  | op, now, slot, delay, start_time, repeat_period,    | one transfer per item
//         |       | has_handler                                         |
// evt     | source| fired_slot, last                                    | one transfer per report
//
// Items are taken one at a time; cmd.ready is high only while the sequencer is idle.
// A cancel completes in the idle state; a set passes through the arming state, and a periodic
// set with catch-up first waits in the divide state (one remainder bit per cycle in the divider).
// A pump scans all slots through the table memories, one read per cycle, and scans again after
// each firing. The alarm table is cleared at reset by valid bits; no clearing pass is needed.
// When the order stamp counter runs full, a renumbering pass runs before the insertion. A
// stalled evt holds the sequencer only when a report has to be pushed; the final report waits
// in the output register while new items go in.
module periodic_alarm_scheduler (
	input wire logic clk,
	input wire logic arst_n,
	pas_cmd_if.sink  cmd,
	pas_evt_if.source evt
);

	localparam int N = pas_pkg::NUM_ALARMS;
	localparam int IW = pas_pkg::IDX_W;
	localparam int CW = pas_pkg::CNT_W;
	localparam int TW = pas_pkg::TIME_W;
	localparam int SW = pas_pkg::STAMP_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DIV    = 4'd1;
	localparam logic [3:0] S_ARM    = 4'd2;
	localparam logic [3:0] S_SCAN   = 4'd3;
	localparam logic [3:0] S_FIRE   = 4'd4;
	localparam logic [3:0] S_REARM  = 4'd5;
	localparam logic [3:0] S_DONE   = 4'd6;
	localparam logic [3:0] S_RN_OUT = 4'd7;
	localparam logic [3:0] S_RN_HD  = 4'd8;
	localparam logic [3:0] S_RN_IN  = 4'd9;
	localparam logic [3:0] S_RN_WR  = 4'd10;

	logic [3:0]    state_q;

	// per-slot flags in flops, cleared at reset
	logic [N-1:0]  armed_q;
	logic [N-1:0]  hnd_q;
	logic [SW-1:0] stamp_cnt_q;

	// item and arming registers
	logic [TW-1:0] now_q;
	logic [TW-1:0] nowp_q;
	logic [TW-1:0] when_q;
	logic [TW-1:0] per_q;
	logic [TW-1:0] ftp_q;
	logic [IW-1:0] arm_idx_q;
	logic          ret_pump_q;

	// scan engine
	logic [CW-1:0] rd_cnt_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          found_q;
	logic [IW-1:0] best_idx_q;
	logic [TW-1:0] best_ft_q;
	logic [TW-1:0] best_per_q;
	logic [SW-1:0] best_st_q;

	// report buffering
	logic          pend_vld_q;
	logic [IW-1:0] pend_idx_q;
	logic          out_vld_q;
	logic [pas_pkg::SLOT_W-1:0] out_slot_q;
	logic          out_last_q;

	// stamp renumbering
	logic [CW-1:0] rn_cnt_q;
	logic [SW-1:0] stamp_i_q;
	logic [IW-1:0] rank_acc_q;
	logic [IW-1:0] rank_q [N];

	// memory ports
	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic            tp_we;
	logic [2*TW-1:0] tp_wdata;
	logic [2*TW-1:0] tp_rdata;
	logic            st_we;
	logic [IW-1:0]   st_waddr;
	logic [SW-1:0]   st_wdata;
	logic [SW-1:0]   st_rdata;

	logic [TW-1:0] rd_ft;
	logic [TW-1:0] rd_per;
	logic          scan_issue;
	logic          loop_done;
	logic          acc;
	logic          slot_ok;
	logic [IW-1:0] s_idx;
	logic [IW-1:0] rn_idx;
	logic          rn_end;
	logic          out_free;
	logic          out_push;
	logic          cand;
	logic          better;
	logic          fire_hnd;
	logic          need_push;
	logic [TW-1:0] in_now;
	logic [TW-1:0] in_start;
	logic [TW-1:0] in_per;
	logic          div_go;

	pas_pkg::div_req_t div_req;
	pas_pkg::div_rsp_t div_rsp;

	assign acc      = cmd.valid && cmd.ready;
	assign slot_ok  = 32'(cmd.slot) < N;
	assign s_idx    = IW'(cmd.slot);
	assign rn_idx   = rn_cnt_q[IW-1:0];
	assign rn_end   = rn_cnt_q == CW'(N);
	assign out_free = !out_vld_q || evt.ready;
	assign in_now   = TW'(cmd.now);
	assign in_start = TW'(cmd.start_time);
	assign in_per   = TW'(cmd.repeat_period);

	assign rd_ft  = tp_rdata[2*TW-1:TW];
	assign rd_per = tp_rdata[TW-1:0];

	assign loop_done = (rd_cnt_q == CW'(N)) && !rd_vld_s1;

	// candidate compare on the entry just read
	assign cand   = armed_q[rd_idx_s1] && (rd_ft <= now_q);
	assign better = !found_q || (rd_ft < best_ft_q) ||
		((rd_ft == best_ft_q) && (st_rdata < best_st_q));

	assign fire_hnd  = hnd_q[best_idx_q];
	assign need_push = fire_hnd && pend_vld_q;

	// a report enters the output register this cycle
	assign out_push = out_free && (((state_q == S_FIRE) && need_push) ||
		((state_q == S_DONE) && pend_vld_q));

	// catch-up of a periodic set needs the remainder of (now - start) / period
	assign div_go = acc && (cmd.op == pas_pkg::OP_PERIODIC) && slot_ok &&
		(in_per != '0) && (in_start <= in_now);

	assign div_req.start    = div_go;
	assign div_req.dividend = in_now - in_start;
	assign div_req.divisor  = in_per;

	pas_rem_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// fire time and period
	pas_ram #(.WIDTH(2 * TW), .DEPTH(N)) u_time_ram (
		.clk   (clk),
		.we    (tp_we),
		.waddr (arm_idx_q),
		.wdata (tp_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (tp_rdata)
	);

	// insertion stamps
	pas_ram #(.WIDTH(SW), .DEPTH(N)) u_stamp_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (st_rdata)
	);

	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = '0;
		scan_issue = 1'b0;
		tp_we      = 1'b0;
		tp_wdata   = {when_q, per_q};
		st_we      = 1'b0;
		st_waddr   = arm_idx_q;
		st_wdata   = stamp_cnt_q;
		// sweep the table, one entry per cycle
		if (((state_q == S_SCAN) || (state_q == S_RN_IN)) && (rd_cnt_q < CW'(N))) begin
			scan_issue = 1'b1;
			rd_en      = 1'b1;
			rd_addr    = rd_cnt_q[IW-1:0];
		end
		// fetch the stamp being ranked
		if ((state_q == S_RN_OUT) && !rn_end && armed_q[rn_idx]) begin
			rd_en   = 1'b1;
			rd_addr = rn_idx;
		end
		// write the new entry
		if ((state_q == S_ARM) && (stamp_cnt_q != pas_pkg::STAMP_MAX)) begin
			tp_we = 1'b1;
			st_we = 1'b1;
		end
		// write back a rank
		if ((state_q == S_RN_WR) && !rn_end && armed_q[rn_idx]) begin
			st_we    = 1'b1;
			st_waddr = rn_idx;
			st_wdata = SW'(rank_q[rn_idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			armed_q     <= '0;
			hnd_q       <= '0;
			stamp_cnt_q <= '0;
			now_q       <= '0;
			nowp_q      <= '0;
			when_q      <= '0;
			per_q       <= '0;
			ftp_q       <= '0;
			arm_idx_q   <= '0;
			ret_pump_q  <= 1'b0;
			rd_cnt_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			best_ft_q   <= '0;
			best_per_q  <= '0;
			best_st_q   <= '0;
			pend_vld_q  <= 1'b0;
			pend_idx_q  <= '0;
			out_vld_q   <= 1'b0;
			out_slot_q  <= '0;
			out_last_q  <= 1'b0;
			rn_cnt_q    <= '0;
			stamp_i_q   <= '0;
			rank_acc_q  <= '0;
			rank_q      <= '{default: '0};
		end else begin
			rd_vld_s1 <= scan_issue;
			rd_idx_s1 <= rd_addr;
			if (scan_issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			// drop the result once the transfer completes and nothing replaces it
			if (evt.valid && evt.ready && !out_push) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						now_q      <= in_now;
						nowp_q     <= in_now + in_per;
						ret_pump_q <= 1'b0;
						arm_idx_q  <= s_idx;
						unique case (cmd.op)
							pas_pkg::OP_PUMP: begin
								rd_cnt_q <= '0;
								found_q  <= 1'b0;
								state_q  <= S_SCAN;
							end
							pas_pkg::OP_ONE_SHOT: begin
								if (slot_ok) begin
									armed_q[s_idx] <= 1'b0;
									hnd_q[s_idx]   <= cmd.has_handler;
									per_q          <= '0;
									when_q         <= in_now + TW'(cmd.delay);
									state_q        <= S_ARM;
								end
							end
							pas_pkg::OP_PERIODIC: begin
								if (slot_ok) begin
									armed_q[s_idx] <= 1'b0;
									hnd_q[s_idx]   <= cmd.has_handler;
									per_q          <= in_per;
									when_q         <= in_start;
									state_q        <= div_go ? S_DIV : S_ARM;
								end
							end
							pas_pkg::OP_CANCEL: begin
								if (slot_ok) begin
									armed_q[s_idx] <= 1'b0;
									hnd_q[s_idx]   <= 1'b0;
								end
							end
						endcase
					end
				end
				S_DIV: begin
					// first fire time after now: now + period - remainder
					if (div_rsp.done) begin
						when_q  <= nowp_q - div_rsp.rem;
						state_q <= S_ARM;
					end
				end
				S_ARM: begin
					if (stamp_cnt_q == pas_pkg::STAMP_MAX) begin
						rn_cnt_q <= '0;
						state_q  <= S_RN_OUT;
					end else begin
						armed_q[arm_idx_q] <= 1'b1;
						stamp_cnt_q        <= stamp_cnt_q + 1'b1;
						if (ret_pump_q) begin
							rd_cnt_q <= '0;
							found_q  <= 1'b0;
							state_q  <= S_SCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SCAN: begin
					if (rd_vld_s1 && cand && better) begin
						found_q    <= 1'b1;
						best_idx_q <= rd_idx_s1;
						best_ft_q  <= rd_ft;
						best_per_q <= rd_per;
						best_st_q  <= st_rdata;
					end
					if (loop_done) begin
						state_q <= found_q ? S_FIRE : S_DONE;
					end
				end
				S_FIRE: begin
					// hold while an earlier report cannot be pushed
					if (!(need_push && !out_free)) begin
						armed_q[best_idx_q] <= 1'b0;
						if (need_push) begin
							out_vld_q  <= 1'b1;
							out_slot_q <= pas_pkg::SLOT_W'(pend_idx_q);
							out_last_q <= 1'b0;
						end
						if (fire_hnd) begin
							pend_vld_q <= 1'b1;
							pend_idx_q <= best_idx_q;
						end
						ftp_q  <= best_ft_q + best_per_q;
						nowp_q <= now_q + best_per_q;
						if (best_per_q != '0) begin
							state_q <= S_REARM;
						end else begin
							rd_cnt_q <= '0;
							found_q  <= 1'b0;
							state_q  <= S_SCAN;
						end
					end
				end
				S_REARM: begin
					when_q     <= (ftp_q <= now_q) ? nowp_q : ftp_q;
					per_q      <= best_per_q;
					arm_idx_q  <= best_idx_q;
					ret_pump_q <= 1'b1;
					state_q    <= S_ARM;
				end
				S_DONE: begin
					if (!pend_vld_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_vld_q  <= 1'b1;
						out_slot_q <= pas_pkg::SLOT_W'(pend_idx_q);
						out_last_q <= 1'b1;
						pend_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				S_RN_OUT: begin
					if (rn_end) begin
						rn_cnt_q <= '0;
						state_q  <= S_RN_WR;
					end else if (!armed_q[rn_idx]) begin
						rn_cnt_q <= rn_cnt_q + 1'b1;
					end else begin
						state_q <= S_RN_HD;
					end
				end
				S_RN_HD: begin
					stamp_i_q  <= st_rdata;
					rank_acc_q <= '0;
					rd_cnt_q   <= '0;
					state_q    <= S_RN_IN;
				end
				S_RN_IN: begin
					// rank = number of armed slots with an older stamp
					if (rd_vld_s1 && armed_q[rd_idx_s1] && (st_rdata < stamp_i_q)) begin
						rank_acc_q <= rank_acc_q + 1'b1;
					end
					if (loop_done) begin
						rank_q[rn_idx] <= rank_acc_q;
						rn_cnt_q       <= rn_cnt_q + 1'b1;
						state_q        <= S_RN_OUT;
					end
				end
				S_RN_WR: begin
					if (rn_end) begin
						stamp_cnt_q <= SW'($countones(armed_q));
						state_q     <= S_ARM;
					end else begin
						rn_cnt_q <= rn_cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready      = state_q == S_IDLE;
	assign evt.valid      = out_vld_q;
	assign evt.fired_slot = out_slot_q;
	assign evt.last       = out_last_q;

endmodule

`default_nettype wire

[hdl/pas_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module pas_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         cmd_valid,
	input wire logic                         cmd_ready,
	input wire logic [pas_pkg::OP_W-1:0]     cmd_op,
	input wire logic                         evt_valid,
	input wire logic                         evt_ready,
	input wire logic [pas_pkg::SLOT_W-1:0]   evt_fired_slot,
	input wire logic                         evt_last
);

	// a stalled report holds
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt_fired_slot) && $stable(evt_last))
		else $error("report changed while stalled");

	// a non-final report means the pump is still in progress
	a_busy_mid_pump: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_last |-> !cmd_ready)
		else $error("new item taken in the middle of a pump");

	// set and cancel produce no reports
	a_no_report_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_op != pas_pkg::OP_PUMP) && !evt_valid |=> !evt_valid)
		else $error("report without a pump");

endmodule

bind periodic_alarm_scheduler pas_chk u_pas_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_op         (cmd.op),
	.evt_valid      (evt.valid),
	.evt_ready      (evt.ready),
	.evt_fired_slot (evt.fired_slot),
	.evt_last       (evt.last)
);

`default_nettype wire

[tb/sv/periodic_alarm_scheduler_test.sv]
`timescale 1ns / 1ps

module periodic_alarm_scheduler_test;

	localparam int N_SLOTS = 8;
	localparam int REPORT_CAP = 8;
	localparam logic [62:0] T_MAX = {63{1'b1}};

	typedef struct {
		logic [pas_pkg::OP_W-1:0]   op;
		logic [62:0]                now;
		logic [pas_pkg::SLOT_W-1:0] slot;
		logic [62:0]                delay;
		logic [62:0]                start_time;
		logic [62:0]                repeat_period;
		logic                       has_handler;
		int                         want_n;      // -1: use predictor, else typed-in count
		logic [pas_pkg::SLOT_W-1:0] want_slot;   // first report when want_n > 0
	} alarm_cmd_t;

	typedef struct packed {
		logic [pas_pkg::SLOT_W-1:0] fired_slot;
		logic                       last;
	} firing_t;

	logic clk;
	logic arst_n;
	pas_cmd_if cmd ();
	pas_evt_if evt ();

	periodic_alarm_scheduler u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.evt(evt)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the alarm table
	logic [63:0] sh_fire [N_SLOTS];
	logic [63:0] sh_period [N_SLOTS];
	logic        sh_armed [N_SLOTS];
	logic        sh_handler [N_SLOTS];
	logic [31:0] sh_stamp [N_SLOTS];
	logic [31:0] sh_stamp_cnt;

	firing_t firing_q[$];
	int      fail_cnt;
	logic    no_idle;
	logic [62:0] clock_now;

	// Collapse stamps of armed slots to 0..k-1 keeping their order.
	function automatic void renumber_slots();
		logic [31:0] rank [N_SLOTS];
		int k;
		k = 0;
		for (int i = 0; i < N_SLOTS; i++) begin
			rank[i] = 0;
			if (sh_armed[i]) begin
				k++;
				for (int j = 0; j < N_SLOTS; j++)
					if (sh_armed[j] && sh_stamp[j] < sh_stamp[i])
						rank[i]++;
			end
		end
		for (int i = 0; i < N_SLOTS; i++)
			if (sh_armed[i])
				sh_stamp[i] = rank[i];
		sh_stamp_cnt = 32'(k);
	endfunction

	function automatic void arm_alarm(int s, logic [63:0] when);
		sh_armed[s] = 1'b0;
		if (sh_stamp_cnt == pas_pkg::STAMP_MAX)
			renumber_slots();
		sh_fire[s] = when;
		sh_stamp[s] = sh_stamp_cnt;
		sh_stamp_cnt++;
		sh_armed[s] = 1'b1;
	endfunction

	// Apply one command to the shadow table and queue the firings it reports.
	function automatic int predict_firings(alarm_cmd_t c);
		logic [63:0] now64, when, nxt;
		int best, n, s;
		now64 = {1'b0, c.now};
		n = 0;
		s = c.slot;
		case (c.op)
			pas_pkg::OP_ONE_SHOT: begin
				sh_handler[s] = c.has_handler;
				sh_period[s] = '0;
				arm_alarm(s, now64 + {1'b0, c.delay});
			end
			pas_pkg::OP_PERIODIC: begin
				when = {1'b0, c.start_time};
				if (c.repeat_period != 0 && c.start_time <= c.now)
					when = when + ((now64 - when) / c.repeat_period + 1) * c.repeat_period;
				sh_handler[s] = c.has_handler;
				sh_period[s] = {1'b0, c.repeat_period};
				arm_alarm(s, when);
			end
			pas_pkg::OP_CANCEL: begin
				sh_armed[s] = 1'b0;
				sh_handler[s] = 1'b0;
			end
			default: begin
				forever begin
					best = -1;
					for (int i = 0; i < N_SLOTS; i++) begin
						if (!sh_armed[i] || sh_fire[i] > now64)
							continue;
						if (best < 0 || sh_fire[i] < sh_fire[best] ||
							(sh_fire[i] == sh_fire[best] && sh_stamp[i] < sh_stamp[best]))
							best = i;
					end
					if (best < 0)
						break;
					sh_armed[best] = 1'b0;
					if (sh_period[best] != 0) begin
						nxt = sh_fire[best] + sh_period[best];
						if (nxt <= now64)
							nxt = now64 + sh_period[best];
						arm_alarm(best, nxt);
					end
					if (sh_handler[best] && n < REPORT_CAP) begin
						firing_q.push_back('{fired_slot: pas_pkg::SLOT_W'(best), last: 1'b0});
						n++;
					end
				end
				if (n > 0)
					firing_q[$].last = 1'b1;
			end
		endcase
		return n;
	endfunction

	// Hand one command to the block; valid stays up until the transfer.
	task automatic send_cmd(alarm_cmd_t c);
		int n;
		int first;
		while (!no_idle && $urandom_range(99) < 12) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.op <= c.op;
		cmd.now <= c.now;
		cmd.slot <= c.slot;
		cmd.delay <= c.delay;
		cmd.start_time <= c.start_time;
		cmd.repeat_period <= c.repeat_period;
		cmd.has_handler <= c.has_handler;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		n = predict_firings(c);
		if (c.want_n >= 0) begin
			if (n != c.want_n) begin
				$error("report count: expected %0d, actual %0d", c.want_n, n);
				fail_cnt++;
			end else if (n > 0) begin
				first = firing_q.size() - n;
				if (firing_q[first].fired_slot != c.want_slot) begin
					$error("first fired_slot: expected %0d, actual %0d", c.want_slot,
						firing_q[first].fired_slot);
					fail_cnt++;
				end
			end
		end
	endtask

	// Drop valid after the last transfer before the sender waits.
	task automatic release_cmd();
		cmd.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic alarm_cmd_t mk(logic [pas_pkg::OP_W-1:0] op, logic [62:0] now,
		logic [pas_pkg::SLOT_W-1:0] slot, logic [62:0] dly, logic [62:0] st,
		logic [62:0] per, logic hh, int wn, logic [pas_pkg::SLOT_W-1:0] ws);
		mk = '{op, now, slot, dly, st, per, hh, wn, ws};
	endfunction

	// Accept reports and compare against the oldest expectation.
	always @(posedge clk) begin
		firing_t exp_f;
		if (evt.valid && evt.ready) begin
			if (firing_q.size() == 0) begin
				$error("unexpected report: fired_slot %0d last %0b", evt.fired_slot, evt.last);
				fail_cnt++;
			end else begin
				exp_f = firing_q.pop_front();
				if (evt.fired_slot !== exp_f.fired_slot) begin
					$error("fired_slot: expected %0d, actual %0d", exp_f.fired_slot,
						evt.fired_slot);
					fail_cnt++;
				end
				if (evt.last !== exp_f.last) begin
					$error("last: expected %0b, actual %0b", exp_f.last, evt.last);
					fail_cnt++;
				end
			end
		end
	end

	// Stall the report channel at random, except during the no-idle stretch.
	always @(posedge clk)
		evt.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		alarm_cmd_t dir [$];
		alarm_cmd_t c;
		int r, wait_cnt;
		clk = 1'b0;
		arst_n = 1'b0;
		fail_cnt = 0;
		no_idle = 1'b0;
		cmd.valid = 1'b0;
		cmd.op = pas_pkg::OP_PUMP;
		cmd.now = '0;
		cmd.slot = '0;
		cmd.delay = '0;
		cmd.start_time = '0;
		cmd.repeat_period = '0;
		cmd.has_handler = 1'b0;
		evt.ready = 1'b0;
		for (int i = 0; i < N_SLOTS; i++) begin
			sh_fire[i] = '0;
			sh_period[i] = '0;
			sh_armed[i] = 1'b0;
			sh_handler[i] = 1'b0;
			sh_stamp[i] = '0;
		end
		sh_stamp_cnt = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: empty table, extremes, each op, ties, zero period, silent alarms.
		dir.push_back(mk(pas_pkg::OP_PUMP, T_MAX, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(mk(pas_pkg::OP_ONE_SHOT, 0, 3, 0, 0, 0, 1, 0, 0));
		dir.push_back(mk(pas_pkg::OP_PUMP, 0, 0, 0, 0, 0, 0, 1, 3));
		dir.push_back(mk(pas_pkg::OP_ONE_SHOT, 10, 5, 5, 0, 0, 1, 0, 0));
		dir.push_back(mk(pas_pkg::OP_ONE_SHOT, 10, 2, 5, 0, 0, 1, 0, 0));
		// re-set: goes after slot 2
		dir.push_back(mk(pas_pkg::OP_ONE_SHOT, 10, 5, 5, 0, 0, 1, 0, 0));
		dir.push_back(mk(pas_pkg::OP_PUMP, 14, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(mk(pas_pkg::OP_PUMP, 15, 0, 0, 0, 0, 0, -1, 0));
		dir.push_back(mk(pas_pkg::OP_PERIODIC, 20, 1, 0, 5, 7, 1, 0, 0));   // catch-up
		// zero period, already due
		dir.push_back(mk(pas_pkg::OP_PERIODIC, 20, 6, 0, 3, 0, 1, 0, 0));
		dir.push_back(mk(pas_pkg::OP_ONE_SHOT, 20, 7, 1, 0, 0, 0, 0, 0));   // silent
		// late periodic re-arm
		dir.push_back(mk(pas_pkg::OP_PUMP, 100, 0, 0, 0, 0, 0, -1, 0));
		dir.push_back(mk(pas_pkg::OP_CANCEL, 100, 1, 0, 0, 0, 0, 0, 0));
		dir.push_back(mk(pas_pkg::OP_PUMP, 1000, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(mk(pas_pkg::OP_PERIODIC, 0, 4, 0, T_MAX, T_MAX, 1, 0, 0));
		dir.push_back(mk(pas_pkg::OP_ONE_SHOT, T_MAX, 0, T_MAX, 0, 0, 1, 0, 0));
		dir.push_back(mk(pas_pkg::OP_PERIODIC, T_MAX, 1, 0, 0, T_MAX, 1, 0, 0));
		dir.push_back(mk(pas_pkg::OP_PUMP, T_MAX, 0, 0, 0, 0, 0, 1, 4));
		for (int i = 0; i < N_SLOTS; i++)
			dir.push_back(mk(pas_pkg::OP_ONE_SHOT, 0, pas_pkg::SLOT_W'(i), 0, 0, 0, 1, 0, 0));
		dir.push_back(mk(pas_pkg::OP_PUMP, 0, 0, 0, 0, 0, 0, 8, 0));
		for (int i = 0; i < N_SLOTS; i++)
			dir.push_back(mk(pas_pkg::OP_CANCEL, 0, pas_pkg::SLOT_W'(i), 0, 0, 0, 0, 0, 0));
		foreach (dir[i])
			send_cmd(dir[i]);
		release_cmd();

		// Hold the sender until every expected report has drained.
		while (firing_q.size() != 0)
			@(posedge clk);

		// Random: mostly set/pump traffic on a rising clock, some noise at extremes.
		clock_now = 0;
		for (int k = 0; k < 65; k++) begin
			no_idle = (k >= 20 && k < 40);
			r = $urandom_range(99);
			clock_now = clock_now + 63'($urandom_range(20));
			c = mk(pas_pkg::OP_PUMP, clock_now, pas_pkg::SLOT_W'($urandom_range(N_SLOTS - 1)),
				63'($urandom_range(40)), 63'(clock_now + $urandom_range(60) - 30),
				63'($urandom_range(25)), $urandom_range(99) < 85, -1, 0);
			if (c.start_time > T_MAX - 200)
				c.start_time = 0;
			if (r < 35)
				c.op = pas_pkg::OP_ONE_SHOT;
			else if (r < 55)
				c.op = pas_pkg::OP_PERIODIC;
			else if (r < 63)
				c.op = pas_pkg::OP_CANCEL;
			if (r >= 95) begin
				// wide fields, all bits toggling
				c.now = 63'({$urandom, $urandom});
				c.delay = 63'({$urandom, $urandom} >> $urandom_range(62));
				c.start_time = 63'({$urandom, $urandom});
				c.repeat_period = 63'({$urandom, $urandom} >> $urandom_range(62));
				if (c.now > T_MAX - c.delay)
					c.delay = T_MAX - c.now;
				if (c.op == pas_pkg::OP_PERIODIC && c.repeat_period == 0)
					c.repeat_period = 63'(1 + $urandom_range(9));
				if (c.op == pas_pkg::OP_PERIODIC && c.start_time > c.now)
					c.start_time = c.now;
				if (c.op == pas_pkg::OP_PUMP)
					c.now = clock_now;
				if (c.op == pas_pkg::OP_PERIODIC)
					c.repeat_period = c.repeat_period & 63'h3fff_ffff;
			end
			send_cmd(c);
		end
		release_cmd();
		no_idle = 1'b0;

		wait_cnt = 0;
		while (firing_q.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (200) @(posedge clk);
		if (fail_cnt == 0 && firing_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

[periodic_alarm_scheduler.f]
hdl/pas_pkg.sv
hdl/pas_cmd_if.sv
hdl/pas_evt_if.sv
hdl/pas_ram.sv
hdl/pas_rem_div.sv
hdl/periodic_alarm_scheduler.sv
hdl/pas_chk.sv
tb/sv/periodic_alarm_scheduler_test.sv
